FILE: sv/sde_pkg.sv
// shared types, constants and priority decode for the sprite descriptor expander
package sde_pkg;

  localparam logic [15:0] TOP_MASK   = 16'hc000;
  localparam logic [15:0] TOP_BOTH   = 16'hc000;
  localparam logic [15:0] TOP_HIGH   = 16'h8000;
  localparam logic [15:0] MODE_ALT1  = 16'd1;
  localparam logic [15:0] MODE_ALT2  = 16'd2;
  localparam logic [8:0]  X_WRAP     = 9'd320;
  localparam logic signed [10:0] X_SPAN  = 11'sd512;
  localparam logic signed [10:0] X_ORIG  = 11'sd304;
  localparam logic signed [10:0] Y_ORIG  = 11'sd240;

  localparam logic [1:0] CFG_CHIP = 2'd0;
  localparam logic [1:0] CFG_MODE = 2'd1;
  localparam logic [1:0] CFG_FLIP = 2'd2;

  localparam logic [1:0] PF_MASK4  = 2'd0;
  localparam logic [1:0] PF_MASK16 = 2'd1;
  localparam logic [1:0] PF_MASK64 = 2'd2;

  localparam logic [2:0] SP_4  = 3'd0;
  localparam logic [2:0] SP_8  = 3'd1;
  localparam logic [2:0] SP_16 = 3'd2;
  localparam logic [2:0] SP_32 = 3'd3;
  localparam logic [2:0] SP_64 = 3'd4;

  typedef struct packed {
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic last;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [1:0] pf;
    logic [2:0] sp;
    logic       tr;
  } prio_t;

  function automatic prio_t decode_prio(input logic [15:0] pos, input logic second,
                                        input logic [15:0] mode);
    prio_t       p;
    logic [15:0] top;
    top  = pos & TOP_MASK;
    p.tr = 1'b0;
    if (second) begin
      if (top == TOP_BOTH) p.sp = SP_4;
      else if (top != 16'd0) p.sp = SP_16;
      else p.sp = SP_64;
      if (pos[13]) p.tr = 1'b1;
      if (mode == MODE_ALT2) begin
        if (pos[15]) p.tr = 1'b1;
        if (top == TOP_BOTH) p.pf = PF_MASK4;
        else if (top == TOP_HIGH) p.pf = PF_MASK16;
        else p.pf = PF_MASK64;
      end else begin
        p.pf = pos[15] ? PF_MASK16 : PF_MASK64;
      end
    end else begin
      p.sp = pos[15] ? SP_8 : SP_32;
      if (mode == MODE_ALT1) begin
        p.pf = (top != 16'd0) ? PF_MASK16 : PF_MASK64;
      end else begin
        if (top == TOP_BOTH) p.pf = PF_MASK4;
        else if (top == TOP_HIGH) p.pf = PF_MASK16;
        else p.pf = PF_MASK64;
      end
    end
    return p;
  endfunction

endpackage

FILE: sv/sde_ctrl.sv
// controller state machine for the sprite descriptor expander
module sde_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sde_pkg::sts_t sts_i,
  output sde_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   fire;
  logic   accept;

  assign fire       = (state_q == ST_EMIT) && sts_i.out_free;
  assign in_ready_o = (state_q == ST_IDLE) || (fire && sts_i.last);
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.load = accept;
  assign cmd_o.emit = fire;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !sts_i.skip) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (fire && sts_i.last) begin
          state_d = (accept && !sts_i.skip) ? ST_EMIT : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/sde_dpath.sv
// datapath: config registers, descriptor decode, slice counter and output register
module sde_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [15:0]        attr_word_i,
  input  logic [15:0]        tile_word_i,
  input  logic [15:0]        pos_word_i,
  input  logic               odd_frame_i,
  input  sde_pkg::cmd_t      cmd_i,
  output sde_pkg::sts_t      sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        tile_code_o,
  output logic [4:0]         colour_o,
  output logic               flip_x_o,
  output logic               flip_y_o,
  output logic signed [9:0]  x_pos_o,
  output logic signed [10:0] y_pos_o,
  output logic [1:0]         playfield_prio_o,
  output logic [2:0]         sprite_prio_o,
  output logic               translucent_o,
  output logic               last_slice_o
);

  logic        chip_q;
  logic [15:0] mode_q;
  logic        flip_q;

  // decoded descriptor
  logic [15:0]        base_q;
  logic [4:0]         colour_q;
  logic               fx_q, fy_q, fy_desc_q, dir_q;
  logic signed [9:0]  x_q;
  logic signed [10:0] y_q;
  sde_pkg::prio_t     prio_q;
  logic [2:0]         idx_q;

  logic               out_valid_q;

  // decode at load
  logic [2:0]         m;
  logic [15:0]        base;
  logic [8:0]         x9;
  logic signed [10:0] xa, xf, ya, yf;
  sde_pkg::prio_t     prio;

  // per slice
  logic [15:0]        slice_tile;
  logic signed [11:0] slice_y;
  logic [11:0]        yoff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_q <= 1'b0;
      mode_q <= 16'd0;
      flip_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sde_pkg::CFG_CHIP: chip_q <= cfg_data_i[0];
        sde_pkg::CFG_MODE: mode_q <= cfg_data_i;
        sde_pkg::CFG_FLIP: flip_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (attr_word_i[10:9])
      2'd0:    m = 3'd0;
      2'd1:    m = 3'd1;
      2'd2:    m = 3'd3;
      default: m = 3'd7;
    endcase
    base = tile_word_i & ~{13'd0, m};
    if (!attr_word_i[14]) base = base + {13'd0, m};
    x9 = pos_word_i[8:0];
    xa = $signed({2'b00, x9}) - ((x9 >= sde_pkg::X_WRAP) ? sde_pkg::X_SPAN : 11'sd0);
    xf = flip_q ? xa : (sde_pkg::X_ORIG - xa);
    ya = $signed({{2{attr_word_i[8]}}, attr_word_i[8:0]});
    yf = flip_q ? ya : (sde_pkg::Y_ORIG - ya);
    prio = sde_pkg::decode_prio(pos_word_i, chip_q, mode_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q    <= base;
      colour_q  <= pos_word_i[13:9];
      fx_q      <= attr_word_i[13] ^ flip_q;
      fy_q      <= attr_word_i[14] ^ flip_q;
      fy_desc_q <= attr_word_i[14];
      dir_q     <= flip_q;
      x_q       <= xf[9:0];
      y_q       <= yf;
      prio_q    <= prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
    end else if (cmd_i.load) begin
      idx_q <= m;
    end else if (cmd_i.emit) begin
      idx_q <= idx_q - 3'd1;
    end
  end

  assign slice_tile = fy_desc_q ? (base_q + {13'd0, idx_q}) : (base_q - {13'd0, idx_q});
  assign yoff       = {5'd0, idx_q, 4'd0};
  assign slice_y    = dir_q ? ($signed({y_q[10], y_q}) + $signed(yoff))
                            : ($signed({y_q[10], y_q}) - $signed(yoff));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      tile_code_o      <= slice_tile;
      colour_o         <= colour_q;
      flip_x_o         <= fx_q;
      flip_y_o         <= fy_q;
      x_pos_o          <= x_q;
      y_pos_o          <= slice_y[10:0];
      playfield_prio_o <= prio_q.pf;
      sprite_prio_o    <= prio_q.sp;
      translucent_o    <= prio_q.tr;
      last_slice_o     <= (idx_q == 3'd0);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.skip     = (tile_word_i == 16'd0) || (attr_word_i[12] && odd_frame_i);
  assign sts_o.last     = (idx_q == 3'd0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

FILE: sv/sprite_descriptor_expander_unit.sv
// top level of the sprite descriptor expander
// Takes one sprite descriptor per item and emits one tile draw command per
// 16-pixel slice, from the highest slice down, the final one flagged by
// last_slice_o. A 1x/2x/4x/8x sprite gives 1/2/4/8 commands: one command leaves
// the output register per cycle while the output is not stalled, and the next
// descriptor is taken in the cycle that loads the final command. An unused or
// flashed-off descriptor gives no command. Configuration writes are always
// accepted and should be made while no descriptor is in flight.
module sprite_descriptor_expander_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        attr_word_i,
  input  logic [15:0]        tile_word_i,
  input  logic [15:0]        pos_word_i,
  input  logic               odd_frame_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        tile_code_o,
  output logic [4:0]         colour_o,
  output logic               flip_x_o,
  output logic               flip_y_o,
  output logic signed [9:0]  x_pos_o,
  output logic signed [10:0] y_pos_o,
  output logic [1:0]         playfield_prio_o,
  output logic [2:0]         sprite_prio_o,
  output logic               translucent_o,
  output logic               last_slice_o
);

  sde_pkg::cmd_t cmd;
  sde_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  sde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sde_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .attr_word_i      (attr_word_i),
    .tile_word_i      (tile_word_i),
    .pos_word_i       (pos_word_i),
    .odd_frame_i      (odd_frame_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .tile_code_o      (tile_code_o),
    .colour_o         (colour_o),
    .flip_x_o         (flip_x_o),
    .flip_y_o         (flip_y_o),
    .x_pos_o          (x_pos_o),
    .y_pos_o          (y_pos_o),
    .playfield_prio_o (playfield_prio_o),
    .sprite_prio_o    (sprite_prio_o),
    .translucent_o    (translucent_o),
    .last_slice_o     (last_slice_o)
  );

endmodule
